[src/bvc_pkg.sv]
`timescale 1ns / 1ps
package bvc_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;
	localparam int ZB_BITS   = 16;
	localparam int DIV_BITS  = WORD_BITS + FRAC_BITS;
	localparam int SQ_STEPS  = WORD_BITS;
	localparam int SQ_XBITS  = 2 * WORD_BITS;
	localparam int SQ_RBITS  = WORD_BITS + 2;

	typedef logic [WORD_BITS-1:0] word_t;
	typedef logic [DIV_BITS-1:0]  quo_t;

	typedef enum logic [1:0] {
		REG_MASS = 2'd0,
		REG_FLP  = 2'd1,
		REG_FLN  = 2'd2,
		REG_ZB   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] mv;
		word_t absr;
		logic  pos;
		logic  sat;
		logic  arrived;
		logic  bad;
		logic  mzero;
		logic  hold;
	} side_t;

endpackage

[src/bvc_div_cell.sv]
`timescale 1ns / 1ps
module bvc_div_cell import bvc_pkg::*; (
	input  logic  clk,
	input  logic  en,
	input  word_t rem_i,
	input  quo_t  nq_i,
	input  word_t den_i,
	output word_t rem_o,
	output quo_t  nq_o,
	output word_t den_o
);

	logic [WORD_BITS:0] trial;
	logic               ge;
	logic [WORD_BITS:0] diff;

	assign trial = {rem_i, nq_i[DIV_BITS-1]};
	assign ge    = trial >= {1'b0, den_i};
	assign diff  = trial - {1'b0, den_i};

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
			nq_o  <= {nq_i[DIV_BITS-2:0], ge};
			den_o <= den_i;
		end
	end

endmodule

[src/bvc_sqrt_cell.sv]
`timescale 1ns / 1ps
module bvc_sqrt_cell import bvc_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [SQ_RBITS-1:0] rem_i,
	input  logic [SQ_XBITS-1:0] x_i,
	input  word_t               root_i,
	output logic [SQ_RBITS-1:0] rem_o,
	output logic [SQ_XBITS-1:0] x_o,
	output word_t               root_o
);

	logic [SQ_RBITS+1:0] r4;
	logic [SQ_RBITS+1:0] trial;
	logic [SQ_RBITS+1:0] diff;
	logic                ge;

	assign r4    = {rem_i, x_i[SQ_XBITS-1:SQ_XBITS-2]};
	assign trial = {2'b00, root_i, 2'b01};
	assign ge    = r4 >= trial;
	assign diff  = r4 - trial;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_o  <= ge ? diff[SQ_RBITS-1:0] : r4[SQ_RBITS-1:0];
			root_o <= {root_i[WORD_BITS-2:0], ge};
			x_o    <= {x_i[SQ_XBITS-3:0], 2'b00};
		end
	end

endmodule

[src/braking_limited_velocity_command.sv]
`timescale 1ns / 1ps
// Pipeline: 2 front stages, 48 divider cells, 1 multiply stage, 32 square-root
// cells, 1 output register. Throughput: one item per cycle while s_tready is
// high; a two-entry output buffer absorbs stalls.
// Reset (arst_n low, asynchronous): pipeline and output empty, registers
// mass = 5.0, force limits = 0, zero band = 1 LSB.
module braking_limited_velocity_command import bvc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,   // distance, match_velocity, frame_time
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // velocity, arrived, saturated, bad_time, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  reg_idx_t    cfg_index,
	input  word_t       cfg_data
);

	localparam int PW = 2 * WORD_BITS + 1;
	localparam int DW = WORD_BITS + FRAC_BITS + 2;
	localparam int SW = DIV_BITS + 2;
	localparam int OW = WORD_BITS + 3;

	word_t mass_q, flp_q, fln_q;
	logic [ZB_BITS-1:0] zb_q;

	logic en;
	logic sk_v_q, out_v_q;
	logic [OW-1:0] out_q, sk_q;

	assign cfg_ready = 1'b1;
	assign en        = !sk_v_q;
	assign s_tready  = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q <= word_t'(327680);
			flp_q  <= '0;
			fln_q  <= '0;
			zb_q   <= ZB_BITS'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MASS: mass_q <= cfg_data;
				REG_FLP:  flp_q  <= cfg_data;
				REG_FLN:  fln_q  <= cfg_data;
				REG_ZB:   zb_q   <= cfg_data[ZB_BITS-1:0];
			endcase
		end
	end

	// stage 1: match_velocity * frame_time
	logic v_s1;
	logic signed [WORD_BITS-1:0] d_s1, mv_s1;
	word_t t_s1;
	logic signed [PW-1:0] prod_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= s_tdata[WORD_BITS-1:0];
			mv_s1   <= s_tdata[2*WORD_BITS-1:WORD_BITS];
			t_s1    <= s_tdata[3*WORD_BITS-1:2*WORD_BITS];
			prod_s1 <= $signed({{(WORD_BITS+1){s_tdata[2*WORD_BITS-1]}},
				s_tdata[2*WORD_BITS-1:WORD_BITS]}) * $signed({1'b0, s_tdata[3*WORD_BITS-1:2*WORD_BITS]});
		end
	end

	// stage 2: residual, clamp, band check, limit select
	logic signed [PW-1:0] sh;
	logic signed [DW-1:0] diff;
	logic                 r_ovf;
	logic signed [WORD_BITS-1:0] r;
	word_t absr, limit;
	logic  bad, arrived, pos;
	side_t side2;

	assign sh    = prod_s1 >>> FRAC_BITS;
	assign diff  = DW'(d_s1) - sh[DW-1:0];
	assign r_ovf = !(&diff[DW-1:WORD_BITS-1]) && (|diff[DW-1:WORD_BITS-1]);
	assign r     = r_ovf ? {diff[DW-1], {(WORD_BITS-1){!diff[DW-1]}}} : diff[WORD_BITS-1:0];
	assign absr  = r[WORD_BITS-1] ? word_t'(-r) : word_t'(r);
	assign bad   = t_s1 == '0;
	assign pos   = !r[WORD_BITS-1] && (r != '0);
	assign arrived = !bad && (absr <= {{(WORD_BITS-ZB_BITS){1'b0}}, zb_q});
	assign limit = pos ? flp_q : fln_q;

	always_comb begin
		side2.mv      = mv_s1;
		side2.absr    = absr;
		side2.pos     = pos;
		side2.sat     = !bad && r_ovf;
		side2.arrived = arrived;
		side2.bad     = bad;
		side2.mzero   = mass_q == '0;
		side2.hold    = bad || arrived || (limit == '0);
	end

	logic v_s2;
	side_t side_s2;
	word_t t_s2, mass_s2;
	quo_t  nqi_s2, nqa_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2 <= side2;
			t_s2    <= t_s1;
			mass_s2 <= mass_q;
			nqi_s2  <= {absr, {FRAC_BITS{1'b0}}};
			nqa_s2  <= {limit, {FRAC_BITS{1'b0}}};
		end
	end

	// divider chain: ideal speed and acceleration side by side
	word_t irem [DIV_BITS+1];
	quo_t  inq  [DIV_BITS+1];
	word_t iden [DIV_BITS+1];
	word_t arem [DIV_BITS+1];
	quo_t  anq  [DIV_BITS+1];
	word_t aden [DIV_BITS+1];
	side_t dside [DIV_BITS+1];
	logic  dv    [DIV_BITS+1];

	assign irem[0]  = '0;
	assign inq[0]   = nqi_s2;
	assign iden[0]  = t_s2;
	assign arem[0]  = '0;
	assign anq[0]   = nqa_s2;
	assign aden[0]  = mass_s2;
	assign dside[0] = side_s2;
	assign dv[0]    = v_s2;

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		bvc_div_cell u_ideal (
			.clk(clk), .en(en),
			.rem_i(irem[k]), .nq_i(inq[k]), .den_i(iden[k]),
			.rem_o(irem[k+1]), .nq_o(inq[k+1]), .den_o(iden[k+1])
		);
		bvc_div_cell u_accel (
			.clk(clk), .en(en),
			.rem_i(arem[k]), .nq_i(anq[k]), .den_i(aden[k]),
			.rem_o(arem[k+1]), .nq_o(anq[k+1]), .den_o(aden[k+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv[k+1] <= 1'b0;
			else if (en) dv[k+1] <= dv[k];
		end
		always_ff @(posedge clk) begin
			if (en) dside[k+1] <= dside[k];
		end
	end

	// stage 3: clamp acceleration, a * |r| / 2
	side_t dend;
	quo_t  araw;
	logic  a_ovf;
	word_t accel;
	side_t side3;

	assign dend  = dside[DIV_BITS];
	assign araw  = anq[DIV_BITS];
	assign a_ovf = |araw[DIV_BITS-1:WORD_BITS];
	assign accel = a_ovf ? '1 : araw[WORD_BITS-1:0];

	always_comb begin
		side3     = dend;
		side3.sat = dend.sat || (!dend.hold && !dend.mzero && a_ovf);
	end

	logic v_s3;
	side_t side_s3;
	quo_t  ideal_s3;
	logic [SQ_XBITS-1:0] x_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= dv[DIV_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3  <= side3;
			ideal_s3 <= inq[DIV_BITS];
			x_s3     <= (SQ_XBITS'(accel) * SQ_XBITS'(dend.absr)) >> 1;
		end
	end

	// square-root chain, one result bit per cell
	logic [SQ_RBITS-1:0] srem [SQ_STEPS+1];
	logic [SQ_XBITS-1:0] sx   [SQ_STEPS+1];
	word_t               sroot[SQ_STEPS+1];
	side_t               sside[SQ_STEPS+1];
	quo_t                sideal[SQ_STEPS+1];
	logic                sv   [SQ_STEPS+1];

	assign srem[0]   = '0;
	assign sx[0]     = x_s3;
	assign sroot[0]  = '0;
	assign sside[0]  = side_s3;
	assign sideal[0] = ideal_s3;
	assign sv[0]     = v_s3;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		bvc_sqrt_cell u_cell (
			.clk(clk), .en(en),
			.rem_i(srem[k]), .x_i(sx[k]), .root_i(sroot[k]),
			.rem_o(srem[k+1]), .x_o(sx[k+1]), .root_o(sroot[k+1])
		);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sv[k+1] <= 1'b0;
			else if (en) sv[k+1] <= sv[k];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				sside[k+1]  <= sside[k];
				sideal[k+1] <= sideal[k];
			end
		end
	end

	// final: min, sign, add, clamp
	side_t fs;
	quo_t  brake, speed;
	logic signed [SW-1:0] sum;
	logic  v_ovf;
	word_t vel;
	logic  fsat;
	logic [OW-1:0] res;

	assign fs    = sside[SQ_STEPS];
	assign brake = quo_t'(sroot[SQ_STEPS]);
	assign speed = (fs.mzero || sideal[SQ_STEPS] < brake) ? sideal[SQ_STEPS] : brake;
	assign sum   = SW'(fs.mv) + (fs.pos ? $signed({2'b00, speed}) : -$signed({2'b00, speed}));
	assign v_ovf = !(&sum[SW-1:WORD_BITS-1]) && (|sum[SW-1:WORD_BITS-1]);

	always_comb begin
		if (fs.hold) begin
			vel  = fs.mv;
			fsat = fs.sat;
		end else begin
			vel  = v_ovf ? {sum[SW-1], {(WORD_BITS-1){!sum[SW-1]}}} : sum[WORD_BITS-1:0];
			fsat = fs.sat || v_ovf;
		end
		res = {fs.bad, fsat, fs.arrived, vel};
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			sk_v_q  <= 1'b0;
		end else if (en) begin
			if (out_v_q && !m_tready) sk_v_q <= sv[SQ_STEPS];
			else out_v_q <= sv[SQ_STEPS];
		end else if (m_tready) begin
			sk_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (out_v_q && !m_tready) sk_q <= res;
			else out_q <= res;
		end else if (m_tready) begin
			out_q <= sk_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {5'b0, out_q};

endmodule
